[rtl/crd_pkg.sv]
`timescale 1ns / 1ps
// Package for the camera ray direction core: payload structs, register indexes,
// fixed-point constants and series tables. Depends on nothing.
package crd_pkg;

   localparam int COORD_BITS      = 12;
   localparam int ANGLE_BITS      = 16;
   localparam int OUT_FRAC_BITS   = 15;
   localparam int OUT_BITS        = 16;
   localparam int SIZE_BITS       = 13;
   localparam int ANG_REG_BITS    = 16;
   localparam int FOV_BITS        = 8;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 3;

   localparam int MAG_BITS = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam int DEN_BITS = SIZE_BITS + 10;
   localparam int DEN_LOG_MIN = 9;

   localparam int Q_BITS   = 31;
   localparam int X2_BITS  = 32;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   localparam int SIN_TERMS = 5;
   localparam int COS_TERMS = 6;
   localparam logic [7:0] SIN_K [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_K [COS_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] SIN_RECIP [SIN_TERMS] = '{
      32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd6)};
   localparam logic [31:0] COS_RECIP [COS_TERMS] = '{
      32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
      32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
      32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

   localparam int SINCOS_STAGES = 3 * COS_TERMS + 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_VIEW_YAW     = 3'd2,
      CSR_VIEW_PITCH   = 3'd3,
      CSR_FOV_DEGREES  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quadrant_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] dir_x;
      logic signed [OUT_BITS-1:0] dir_y;
      logic signed [OUT_BITS-1:0] dir_z;
   } rsp_payload_type;

   typedef struct packed {
      logic [Q_BITS-1:0] sin_mag;
      logic              sin_neg;
      logic [Q_BITS-1:0] cos_mag;
      logic              cos_neg;
   } trig_type;

   function automatic int num_bits(int angle_bits);
      return MAG_BITS + FOV_BITS + angle_bits + 1;
   endfunction

   function automatic int quot_bits(int angle_bits);
      return num_bits(angle_bits) - DEN_LOG_MIN;
   endfunction

endpackage

[rtl/camera_ray_direction_core.sv]
`timescale 1ns / 1ps
// Top level of the camera ray direction core: configuration registers, valid
// pipeline, two axis angle units, two sine/cosine units and output rounding.
// Depends on crd_pkg, crd_axis_angle and crd_sincos.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid / req_stall  pixel_x, pixel_y
//   rsp_      out        rsp_valid / rsp_stall  dir_x, dir_y, dir_z
//   csr_      in         csr_write_enable       register index and write data
//
// One transaction is accepted per cycle while no result-side stall holds the pipeline.
// The pipeline depth is set by the one-bit-per-stage offset divider and the
// eighteen stages of the cosine series chain.
// Reset is synchronous, clears the valid pipeline and loads the configuration
// registers with their defaults.
// A stall on the result side while a result is valid freezes every stage at once, and req_stall follows it.
module camera_ray_direction_core #(
   parameter int ANGLE_BITS    = crd_pkg::ANGLE_BITS,
   parameter int OUT_FRAC_BITS = crd_pkg::OUT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  crd_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output crd_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [crd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [crd_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int LATENCY = crd_pkg::quot_bits(ANGLE_BITS) + 3
                            + crd_pkg::SINCOS_STAGES + 2;
   localparam logic [63:0] POS_LIM = ((64'd1 << OUT_FRAC_BITS) - 64'd1 > 64'd32767)
                                     ? 64'd32767 : (64'd1 << OUT_FRAC_BITS) - 64'd1;
   localparam logic [63:0] NEG_LIM = ((64'd1 << OUT_FRAC_BITS) > 64'd32768)
                                     ? 64'd32768 : (64'd1 << OUT_FRAC_BITS);

   logic [crd_pkg::SIZE_BITS-1:0]    image_width_ff;
   logic [crd_pkg::SIZE_BITS-1:0]    image_height_ff;
   logic [crd_pkg::ANG_REG_BITS-1:0] view_yaw_ff;
   logic [crd_pkg::ANG_REG_BITS-1:0] view_pitch_ff;
   logic [crd_pkg::FOV_BITS-1:0]     fov_degrees_ff;
   logic                             adv;
   logic [LATENCY-1:0]               vld_ff;
   logic [ANGLE_BITS-1:0]            yaw_angle;
   logic [ANGLE_BITS-1:0]            pitch_angle;
   crd_pkg::trig_type                yaw_trig;
   crd_pkg::trig_type                pitch_trig;
   logic [63:0]                      prod_x_ff;
   logic [63:0]                      prod_z_ff;
   logic [63:0]                      sin_p_ff;
   logic                             neg_x_ff;
   logic                             neg_y_ff;
   logic                             neg_z_ff;
   crd_pkg::rsp_payload_type         rsp_payload_in;
   crd_pkg::rsp_payload_type         rsp_payload_ff;

   function automatic logic [15:0] to_out(logic [63:0] mag, int shift, logic neg);
      logic [63:0] r;
      r = (mag + (64'd1 << (shift - 1))) >> shift;
      if (neg) begin
         if (r > NEG_LIM) r = NEG_LIM;
         return 16'(64'd0 - r);
      end
      if (r > POS_LIM) r = POS_LIM;
      return 16'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= crd_pkg::SIZE_BITS'(640);
         image_height_ff <= crd_pkg::SIZE_BITS'(480);
         view_yaw_ff     <= '0;
         view_pitch_ff   <= '0;
         fov_degrees_ff  <= crd_pkg::FOV_BITS'(90);
      end else if (csr_write_enable) begin
         case (csr_index)
            crd_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data[crd_pkg::SIZE_BITS-1:0];
            end
            crd_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data[crd_pkg::SIZE_BITS-1:0];
            end
            crd_pkg::CSR_VIEW_YAW: begin
               view_yaw_ff <= csr_write_data[crd_pkg::ANG_REG_BITS-1:0];
            end
            crd_pkg::CSR_VIEW_PITCH: begin
               view_pitch_ff <= csr_write_data[crd_pkg::ANG_REG_BITS-1:0];
            end
            crd_pkg::CSR_FOV_DEGREES: begin
               fov_degrees_ff <= csr_write_data[crd_pkg::FOV_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv       = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   crd_axis_angle #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_yaw_angle (
      .clock   (clock),
      .adv     (adv),
      .pix_i   (req_payload.pixel_x),
      .size_i  (image_width_ff),
      .base_i  (view_yaw_ff),
      .fov_i   (fov_degrees_ff),
      .angle_o (yaw_angle)
   );

   crd_axis_angle #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_pitch_angle (
      .clock   (clock),
      .adv     (adv),
      .pix_i   (req_payload.pixel_y),
      .size_i  (image_height_ff),
      .base_i  (view_pitch_ff),
      .fov_i   (fov_degrees_ff),
      .angle_o (pitch_angle)
   );

   crd_sincos #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_yaw_sincos (
      .clock   (clock),
      .adv     (adv),
      .angle_i (yaw_angle),
      .trig_o  (yaw_trig)
   );

   crd_sincos #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_pitch_sincos (
      .clock   (clock),
      .adv     (adv),
      .angle_i (pitch_angle),
      .trig_o  (pitch_trig)
   );

   always_comb begin
      rsp_payload_in.dir_x = to_out(prod_x_ff, 60 - OUT_FRAC_BITS, neg_x_ff);
      rsp_payload_in.dir_y = to_out(sin_p_ff, 30 - OUT_FRAC_BITS, neg_y_ff);
      rsp_payload_in.dir_z = to_out(prod_z_ff, 60 - OUT_FRAC_BITS, neg_z_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff      <= 64'(pitch_trig.cos_mag) * 64'(yaw_trig.cos_mag);
         prod_z_ff      <= 64'(pitch_trig.cos_mag) * 64'(yaw_trig.sin_mag);
         sin_p_ff       <= 64'(pitch_trig.sin_mag);
         neg_x_ff       <= pitch_trig.cos_neg ^ yaw_trig.cos_neg;
         neg_y_ff       <= pitch_trig.sin_neg;
         neg_z_ff       <= pitch_trig.cos_neg ^ yaw_trig.sin_neg;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = vld_ff[LATENCY-1];
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/crd_div_step.sv]
`timescale 1ns / 1ps
// One restoring long-division step: one quotient bit per stage.
// Depends on crd_pkg.
module crd_div_step #(
   parameter int QUOT_BITS = crd_pkg::quot_bits(crd_pkg::ANGLE_BITS)
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [crd_pkg::DEN_BITS-1:0]  den_i,
   input  logic [crd_pkg::DEN_BITS-1:0]  rem_i,
   input  logic [QUOT_BITS-1:0]          work_i,
   input  logic                          neg_i,
   output logic [crd_pkg::DEN_BITS-1:0]  rem_o,
   output logic [QUOT_BITS-1:0]          work_o,
   output logic                          neg_o
);

   logic [crd_pkg::DEN_BITS:0]   trial;
   logic                         fits;
   logic [crd_pkg::DEN_BITS-1:0] rem_in;
   logic [QUOT_BITS-1:0]         work_in;
   logic [crd_pkg::DEN_BITS-1:0] rem_ff;
   logic [QUOT_BITS-1:0]         work_ff;
   logic                         neg_ff;

   always_comb begin
      trial   = {rem_i, work_i[QUOT_BITS-1]};
      fits    = trial >= {1'b0, den_i};
      rem_in  = fits ? crd_pkg::DEN_BITS'(trial - {1'b0, den_i})
                     : crd_pkg::DEN_BITS'(trial);
      work_in = {work_i[QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         neg_ff  <= neg_i;
      end
   end

   assign rem_o  = rem_ff;
   assign work_o = work_ff;
   assign neg_o  = neg_ff;

endmodule

[rtl/crd_axis_angle.sv]
`timescale 1ns / 1ps
// Angle of one axis: pixel offset, scaled by the field of view, divided by the
// image size in a pipelined long divider and added to the base angle. Depends on
// crd_pkg and crd_div_step.
module crd_axis_angle #(
   parameter int ANGLE_BITS = crd_pkg::ANGLE_BITS
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [crd_pkg::COORD_BITS-1:0]    pix_i,
   input  logic [crd_pkg::SIZE_BITS-1:0]     size_i,
   input  logic [crd_pkg::ANG_REG_BITS-1:0]  base_i,
   input  logic [crd_pkg::FOV_BITS-1:0]      fov_i,
   output logic [ANGLE_BITS-1:0]             angle_o
);

   localparam int NUM_BITS  = crd_pkg::num_bits(ANGLE_BITS);
   localparam int QUOT_BITS = crd_pkg::quot_bits(ANGLE_BITS);
   localparam int MAG_BITS  = crd_pkg::MAG_BITS;
   localparam int DEN_BITS  = crd_pkg::DEN_BITS;

   logic [MAG_BITS-1:0]   div_size;
   logic [MAG_BITS-1:0]   twice;
   logic                  neg_in;
   logic [MAG_BITS-1:0]   mag_in;
   logic [MAG_BITS-1:0]   mag_ff;
   logic                  neg1_ff;
   logic [DEN_BITS-1:0]   den_ff;
   logic [DEN_BITS-1:0]   half_ff;
   logic [NUM_BITS-1:0]   num_in;
   logic [NUM_BITS-1:0]   num_ff;
   logic                  neg2_ff;
   logic [DEN_BITS-1:0]   rem_w  [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  work_w [QUOT_BITS+1];
   logic                  neg_w  [QUOT_BITS+1];
   logic [ANGLE_BITS-1:0] base;
   logic [ANGLE_BITS-1:0] offset;
   logic [ANGLE_BITS-1:0] angle_in;
   logic [ANGLE_BITS-1:0] angle_ff;

   always_comb begin
      div_size = (size_i == '0) ? MAG_BITS'(1) : MAG_BITS'(size_i);
      twice    = MAG_BITS'({pix_i, 1'b0});
      neg_in   = twice < div_size;
      mag_in   = neg_in ? div_size - twice : twice - div_size;
      num_in   = ((NUM_BITS'(mag_ff) * NUM_BITS'(fov_i)) << ANGLE_BITS)
                 + NUM_BITS'(half_ff);
   end

   always_ff @(posedge clock) begin
      den_ff  <= DEN_BITS'(DEN_BITS'(div_size) * DEN_BITS'(720));
      half_ff <= DEN_BITS'(DEN_BITS'(div_size) * DEN_BITS'(360));
      if (adv) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg_in;
         num_ff  <= num_in;
         neg2_ff <= neg1_ff;
      end
   end

   assign rem_w[0]  = DEN_BITS'(num_ff[NUM_BITS-1:QUOT_BITS]);
   assign work_w[0] = num_ff[QUOT_BITS-1:0];
   assign neg_w[0]  = neg2_ff;

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
      crd_div_step #(
         .QUOT_BITS (QUOT_BITS)
      ) u_step (
         .clock  (clock),
         .adv    (adv),
         .den_i  (den_ff),
         .rem_i  (rem_w[i]),
         .work_i (work_w[i]),
         .neg_i  (neg_w[i]),
         .rem_o  (rem_w[i+1]),
         .work_o (work_w[i+1]),
         .neg_o  (neg_w[i+1])
      );
   end

   always_comb begin
      base     = ANGLE_BITS'(base_i);
      offset   = work_w[QUOT_BITS][ANGLE_BITS-1:0];
      angle_in = neg_w[QUOT_BITS] ? base - offset : base + offset;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_o = angle_ff;

endmodule

[rtl/crd_series_term.sv]
`timescale 1ns / 1ps
// One term of the sine or cosine series, s = 1 - floor(x2*s/K), in three stages:
// product, reciprocal multiply, correction. Depends on crd_pkg.
module crd_series_term #(
   parameter logic [7:0]  K     = crd_pkg::SIN_K[0],
   parameter logic [31:0] RECIP = crd_pkg::SIN_RECIP[0]
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [crd_pkg::X2_BITS-1:0]   x2_i,
   input  logic [crd_pkg::Q_BITS-1:0]    s_i,
   output logic [crd_pkg::X2_BITS-1:0]   x2_o,
   output logic [crd_pkg::Q_BITS-1:0]    s_o
);

   logic [63:0] prod_in;
   logic [31:0] v_in;
   logic [31:0] v1_ff;
   logic [31:0] x2a_ff;
   logic [63:0] recip_prod;
   logic [31:0] q0_in;
   logic [31:0] q0_ff;
   logic [31:0] v2_ff;
   logic [31:0] x2b_ff;
   logic [39:0] qk;
   logic [39:0] rest;
   logic [31:0] quot;
   logic [30:0] s_in;
   logic [30:0] s_ff;
   logic [31:0] x2c_ff;

   always_comb begin
      prod_in    = 64'(x2_i) * 64'(s_i);
      v_in       = prod_in[61:30];
      recip_prod = 64'(v1_ff) * 64'(RECIP);
      q0_in      = recip_prod[63:32];
      qk         = 40'(q0_ff) * 40'(K);
      rest       = 40'(v2_ff) - qk;
      quot       = q0_ff + 32'(rest >= 40'(K));
      s_in       = (quot >= 32'(crd_pkg::ONE_Q30)) ? '0
                   : 31'(32'(crd_pkg::ONE_Q30) - quot);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff  <= v_in;
         x2a_ff <= x2_i;
         q0_ff  <= q0_in;
         v2_ff  <= v1_ff;
         x2b_ff <= x2a_ff;
         s_ff   <= s_in;
         x2c_ff <= x2b_ff;
      end
   end

   assign x2_o = x2c_ff;
   assign s_o  = s_ff;

endmodule

[rtl/crd_sincos.sv]
`timescale 1ns / 1ps
// Sine and cosine magnitudes and signs of a binary angle: quarter-turn reduction,
// radian scaling and two pipelined series chains. Depends on crd_pkg and
// crd_series_term.
module crd_sincos #(
   parameter int ANGLE_BITS = crd_pkg::ANGLE_BITS
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [ANGLE_BITS-1:0]  angle_i,
   output crd_pkg::trig_type      trig_o
);

   localparam int SIN_TERMS = crd_pkg::SIN_TERMS;
   localparam int COS_TERMS = crd_pkg::COS_TERMS;
   localparam int X_DLY     = 3 * SIN_TERMS + 1;
   localparam int SIN_PAD   = 3 * COS_TERMS - 3 * SIN_TERMS;
   localparam int QUAD_DLY  = 3 * COS_TERMS + 2;

   logic [63:0]                  x_prod;
   logic [30:0]                  x_in;
   logic [30:0]                  x_ff;
   logic [63:0]                  x2_prod;
   logic [31:0]                  x2_ff;
   logic [30:0]                  x_dly_ff   [X_DLY];
   logic [1:0]                   quad_dly_ff [QUAD_DLY];
   logic [31:0]                  sx2 [SIN_TERMS+1];
   logic [30:0]                  ss  [SIN_TERMS+1];
   logic [31:0]                  cx2 [COS_TERMS+1];
   logic [30:0]                  cs  [COS_TERMS+1];
   logic [63:0]                  sin_prod;
   logic [30:0]                  sin_pad_ff [SIN_PAD];
   crd_pkg::trig_type            trig_in;
   crd_pkg::trig_type            trig_ff;
   logic [30:0]                  sin_val;
   logic [30:0]                  cos_val;

   always_comb begin
      x_prod  = 64'(angle_i[ANGLE_BITS-3:0]) * 64'(crd_pkg::HALF_PI_Q30);
      x_in    = 31'(x_prod >> (ANGLE_BITS - 2));
      x2_prod = 64'(x_ff) * 64'(x_ff);
      sin_prod = 64'(x_dly_ff[X_DLY-1]) * 64'(ss[SIN_TERMS]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= x_in;
         x2_ff <= 32'(x2_prod >> 30);
         x_dly_ff[0] <= x_ff;
         for (int i = 1; i < X_DLY; i++) begin
            x_dly_ff[i] <= x_dly_ff[i-1];
         end
         quad_dly_ff[0] <= angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
         for (int i = 1; i < QUAD_DLY; i++) begin
            quad_dly_ff[i] <= quad_dly_ff[i-1];
         end
         sin_pad_ff[0] <= 31'(sin_prod >> 30);
         for (int i = 1; i < SIN_PAD; i++) begin
            sin_pad_ff[i] <= sin_pad_ff[i-1];
         end
         trig_ff <= trig_in;
      end
   end

   assign sx2[0] = x2_ff;
   assign ss[0]  = crd_pkg::ONE_Q30;
   assign cx2[0] = x2_ff;
   assign cs[0]  = crd_pkg::ONE_Q30;

   for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
      crd_series_term #(
         .K     (crd_pkg::SIN_K[i]),
         .RECIP (crd_pkg::SIN_RECIP[i])
      ) u_term (
         .clock (clock),
         .adv   (adv),
         .x2_i  (sx2[i]),
         .s_i   (ss[i]),
         .x2_o  (sx2[i+1]),
         .s_o   (ss[i+1])
      );
   end

   for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
      crd_series_term #(
         .K     (crd_pkg::COS_K[i]),
         .RECIP (crd_pkg::COS_RECIP[i])
      ) u_term (
         .clock (clock),
         .adv   (adv),
         .x2_i  (cx2[i]),
         .s_i   (cs[i]),
         .x2_o  (cx2[i+1]),
         .s_o   (cs[i+1])
      );
   end

   always_comb begin
      sin_val = sin_pad_ff[SIN_PAD-1];
      cos_val = cs[COS_TERMS];
      case (crd_pkg::quadrant_type'(quad_dly_ff[QUAD_DLY-1]))
         crd_pkg::QUAD_FIRST: begin
            trig_in = '{sin_mag: sin_val, sin_neg: 1'b0, cos_mag: cos_val, cos_neg: 1'b0};
         end
         crd_pkg::QUAD_SECOND: begin
            trig_in = '{sin_mag: cos_val, sin_neg: 1'b0, cos_mag: sin_val, cos_neg: 1'b1};
         end
         crd_pkg::QUAD_THIRD: begin
            trig_in = '{sin_mag: sin_val, sin_neg: 1'b1, cos_mag: cos_val, cos_neg: 1'b1};
         end
         default: begin
            trig_in = '{sin_mag: cos_val, sin_neg: 1'b1, cos_mag: sin_val, cos_neg: 1'b0};
         end
      endcase
   end

   assign trig_o = trig_ff;

endmodule
